// ----- hdl/dcmpt_pkg.sv -----
`timescale 1ns / 1ps

package dcmpt_pkg;

    // Sizing
    localparam int NUM_MOTORS   = 4;
    localparam int SAMPLE_BITS  = 12;
    localparam int MOTOR_IDX_W  = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
    localparam int MOTOR_SEL_W  = 3;
    localparam int SAMPLE_W     = 12;
    localparam int PERIOD_W     = 16;
    localparam int SPEED_REQ_W  = 16;
    localparam int SPEED_W      = 8;
    localparam int MAG_W        = 7;
    localparam int COUNT_W      = 32;
    localparam int PROD_W       = PERIOD_W + MAG_W;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_IDX_W    = 1;

    // x / 100 as (x * ceil(2^30 / 100)) >> 30, exact for x < 2^30 / 76
    localparam int RECIP_SHIFT  = 30;
    localparam int RECIP_W      = 24;
    localparam int DIV_W        = PROD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] DIV100_RECIP = 24'd10737419;

    // Reset values and limits
    localparam logic [PERIOD_W-1:0]       PERIOD_RESET = 16'd8399;
    localparam logic [SAMPLE_W-1:0]       THRESH_RESET = 12'd4095;
    localparam logic signed [SPEED_W-1:0] SPEED_MAX    = 8'sd100;
    localparam logic signed [SPEED_W-1:0] SPEED_MIN    = -8'sd100;

    // Request codes
    typedef enum logic [1:0] {
        REQ_SET_SPEED   = 2'd0,
        REQ_UPDATE      = 2'd1,
        REQ_CLEAR_FLAG  = 2'd2,
        REQ_CLEAR_COUNT = 2'd3
    } req_type_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PWM_PERIOD     = 1'b0,
        CFG_TRIP_THRESHOLD = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0]                    req_type;
        logic [MOTOR_SEL_W-1:0]        motor_sel;
        logic signed [SPEED_REQ_W-1:0] speed_request;
        logic [SAMPLE_W-1:0]           current_sample_a;
        logic [SAMPLE_W-1:0]           current_sample_b;
    } in_item_t;

    typedef struct packed {
        logic [PERIOD_W-1:0]       compare_a;
        logic [PERIOD_W-1:0]       compare_b;
        logic                      compare_valid;
        logic                      id_ok;
        logic signed [SPEED_W-1:0] motor_speed;
        logic                      trip_flag;
        logic [COUNT_W-1:0]        trip_total;
    } out_item_t;

    // Result of the state update for one item
    typedef struct packed {
        logic                      compare_valid;
        logic                      id_ok;
        logic signed [SPEED_W-1:0] motor_speed;
        logic                      trip_flag;
        logic [COUNT_W-1:0]        trip_total;
        logic signed [SPEED_W-1:0] speed_a;
        logic signed [SPEED_W-1:0] speed_b;
    } step_t;

    // Keeps the low SAMPLE_BITS bits of a sample field
    function automatic logic [SAMPLE_W-1:0] sample_mask();
        logic [SAMPLE_W-1:0] m;
        for (int i = 0; i < SAMPLE_W; i++)
        begin
            m[i] = (i < SAMPLE_BITS);
        end
        return m;
    endfunction

endpackage

// ----- hdl/dcmpt_state.sv -----
`timescale 1ns / 1ps

module dcmpt_state (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                upd_en,
    input  dcmpt_pkg::in_item_t                 item,
    input  logic [dcmpt_pkg::SAMPLE_W-1:0]      trip_threshold,
    output dcmpt_pkg::step_t                    step
);
    import dcmpt_pkg::*;

    logic signed [SPEED_W-1:0] speed_reg  [NUM_MOTORS];
    logic signed [SPEED_W-1:0] speed_next [NUM_MOTORS];
    logic [NUM_MOTORS-1:0]     flag_reg;
    logic [NUM_MOTORS-1:0]     flag_next;
    logic [COUNT_W-1:0]        count_reg  [NUM_MOTORS];
    logic [COUNT_W-1:0]        count_next [NUM_MOTORS];

    logic [MOTOR_IDX_W-1:0]    idx;
    logic                      id_ok;
    logic signed [SPEED_W-1:0] clamped;
    logic                      trip_a;
    logic                      trip_b;

    assign idx   = item.motor_sel[MOTOR_IDX_W-1:0];
    assign id_ok = ({1'b0, item.motor_sel} < (MOTOR_SEL_W + 1)'(NUM_MOTORS));

    // Clamp requested speed to +/-100 percent
    always_comb
    begin
        if (item.speed_request > 16'sd100)
            clamped = SPEED_MAX;
        else if (item.speed_request < -16'sd100)
            clamped = SPEED_MIN;
        else
            clamped = item.speed_request[SPEED_W-1:0];
    end

    // Overcurrent: sample strictly above threshold
    assign trip_a = (item.current_sample_a & sample_mask()) > trip_threshold;
    assign trip_b = (item.current_sample_b & sample_mask()) > trip_threshold;

    // Next state for this request
    always_comb
    begin
        speed_next = speed_reg;
        flag_next  = flag_reg;
        count_next = count_reg;
        case (req_type_t'(item.req_type))
            REQ_SET_SPEED:
            begin
                if (id_ok)
                    speed_next[idx] = clamped;
            end
            REQ_UPDATE:
            begin
                if (trip_a)
                begin
                    flag_next[0]  = 1'b1;
                    count_next[0] = count_reg[0] + 1'b1;
                    speed_next[0] = '0;
                end
                if (trip_b)
                begin
                    flag_next[1]  = 1'b1;
                    count_next[1] = count_reg[1] + 1'b1;
                    speed_next[1] = '0;
                end
            end
            REQ_CLEAR_FLAG:
            begin
                if (id_ok)
                    flag_next[idx] = 1'b0;
            end
            REQ_CLEAR_COUNT:
            begin
                if (id_ok)
                    count_next[idx] = '0;
            end
            default:
            begin
                speed_next = speed_reg;
            end
        endcase
    end

    // Report of the addressed motor after the update
    always_comb
    begin
        step.compare_valid = (req_type_t'(item.req_type) == REQ_UPDATE);
        step.id_ok         = id_ok;
        step.motor_speed   = id_ok ? speed_next[idx] : '0;
        step.trip_flag     = id_ok ? flag_next[idx] : 1'b0;
        step.trip_total    = id_ok ? count_next[idx] : '0;
        step.speed_a       = speed_next[0];
        step.speed_b       = speed_next[1];
    end

    // Motor state stores
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= '0;
            for (int i = 0; i < NUM_MOTORS; i++)
            begin
                speed_reg[i] <= '0;
                count_reg[i] <= '0;
            end
        end
        else if (upd_en)
        begin
            flag_reg   <= flag_next;
            speed_reg  <= speed_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- hdl/dcmpt_compare.sv -----
`timescale 1ns / 1ps

module dcmpt_compare (
    input  logic                              clk,
    input  logic                              load_mul,
    input  logic                              load_out,
    input  logic signed [dcmpt_pkg::SPEED_W-1:0] speed,
    input  logic [dcmpt_pkg::PERIOD_W-1:0]    period,
    input  logic                              active,
    output logic [dcmpt_pkg::PERIOD_W-1:0]    compare
);
    import dcmpt_pkg::*;

    logic                  neg;
    logic [MAG_W-1:0]      mag;
    logic [PROD_W-1:0]     prod_reg;
    logic                  neg_reg;
    logic [PERIOD_W-1:0]   period_reg;
    logic [DIV_W-1:0]      scaled;
    logic [PERIOD_W-1:0]   duty;
    logic [PERIOD_W-1:0]   compare_next;
    logic [PERIOD_W-1:0]   compare_reg;

    // Magnitude of speed, at most 100
    assign neg = speed[SPEED_W-1];
    assign mag = neg ? MAG_W'(-speed) : MAG_W'(speed);

    // Stage 2: |speed| * period
    always_ff @(posedge clk)
    begin
        if (load_mul)
        begin
            prod_reg   <= PROD_W'(mag) * PROD_W'(period);
            neg_reg    <= neg;
            period_reg <= period;
        end
    end

    // Stage 3: divide by 100 through reciprocal, reverse direction inverts duty
    assign scaled = DIV_W'(prod_reg) * DIV_W'(DIV100_RECIP);
    assign duty   = scaled[RECIP_SHIFT +: PERIOD_W];

    always_comb
    begin
        if (!active)
            compare_next = '0;
        else if (neg_reg)
            compare_next = period_reg - duty;
        else
            compare_next = duty;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
            compare_reg <= compare_next;
    end

    assign compare = compare_reg;

endmodule

// ----- hdl/dc_motor_pwm_overcurrent_trip_core.sv -----
`timescale 1ns / 1ps
// Channel  | Signals                              | Transfer
// ---------+--------------------------------------+------------------------------
// request  | req_valid, req_ready, req_item       | req_valid & req_ready
// result   | rsp_valid, rsp_ready, rsp_item       | rsp_valid & rsp_ready
// config   | cfg_we, cfg_index, cfg_data          | cfg_we (no wait, no read-back)
//
// One item per cycle sustained while the result is not stalled; the result is registered
// through stages s0 to s3 after the request transfer and is offered from s3.
// Motor state is updated as an item leaves the input register; the compare path
// is two multiplier stages (|speed| * period, then the reciprocal of 100).
// Reset clears all speeds, trip flags and counts and loads the config defaults.
// Stages advance independently, so bubbles close up while the result is stalled.

module dc_motor_pwm_overcurrent_trip_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_ready,
    input  dcmpt_pkg::in_item_t                req_item,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output dcmpt_pkg::out_item_t               rsp_item,
    input  logic                               cfg_we,
    input  logic [dcmpt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dcmpt_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import dcmpt_pkg::*;

    logic [PERIOD_W-1:0] pwm_period_reg;
    logic [SAMPLE_W-1:0] trip_threshold_reg;

    logic      s0_valid_reg;
    in_item_t  s0_item_reg;
    logic      s1_valid_reg;
    step_t     s1_step_reg;
    logic      s2_valid_reg;
    step_t     s2_step_reg;
    logic      s3_valid_reg;
    step_t     s3_step_reg;

    logic      rdy0;
    logic      rdy1;
    logic      rdy2;
    logic      rdy3;
    step_t     step;
    logic [PERIOD_W-1:0] cmp_a;
    logic [PERIOD_W-1:0] cmp_b;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_period_reg     <= PERIOD_RESET;
            trip_threshold_reg <= THRESH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_PWM_PERIOD:     pwm_period_reg     <= cfg_data[PERIOD_W-1:0];
                CFG_TRIP_THRESHOLD: trip_threshold_reg <= cfg_data[SAMPLE_W-1:0];
                default:            pwm_period_reg     <= pwm_period_reg;
            endcase
        end
    end

    // A stage loads when it is empty or its successor takes its contents
    assign rdy3      = !s3_valid_reg || rsp_ready;
    assign rdy2      = !s2_valid_reg || rdy3;
    assign rdy1      = !s1_valid_reg || rdy2;
    assign rdy0      = !s0_valid_reg || rdy1;
    assign req_ready = rdy0;

    // Stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy0)
                s0_valid_reg <= req_valid;
            if (rdy1)
                s1_valid_reg <= s0_valid_reg;
            if (rdy2)
                s2_valid_reg <= s1_valid_reg;
            if (rdy3)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (rdy0)
            s0_item_reg <= req_item;
        if (rdy1)
            s1_step_reg <= step;
        if (rdy2)
            s2_step_reg <= s1_step_reg;
        if (rdy3)
            s3_step_reg <= s2_step_reg;
    end

    // Motor state and trip logic
    dcmpt_state u_state (
        .clk            (clk),
        .rst_n          (rst_n),
        .upd_en         (s0_valid_reg && rdy1),
        .item           (s0_item_reg),
        .trip_threshold (trip_threshold_reg),
        .step           (step)
    );

    // Compare value paths for motors 0 and 1
    dcmpt_compare u_compare_a (
        .clk      (clk),
        .load_mul (rdy2),
        .load_out (rdy3),
        .speed    (s1_step_reg.speed_a),
        .period   (pwm_period_reg),
        .active   (s2_step_reg.compare_valid),
        .compare  (cmp_a)
    );

    dcmpt_compare u_compare_b (
        .clk      (clk),
        .load_mul (rdy2),
        .load_out (rdy3),
        .speed    (s1_step_reg.speed_b),
        .period   (pwm_period_reg),
        .active   (s2_step_reg.compare_valid),
        .compare  (cmp_b)
    );

    // Result
    assign rsp_valid              = s3_valid_reg;
    assign rsp_item.compare_a     = cmp_a;
    assign rsp_item.compare_b     = cmp_b;
    assign rsp_item.compare_valid = s3_step_reg.compare_valid;
    assign rsp_item.id_ok         = s3_step_reg.id_ok;
    assign rsp_item.motor_speed   = s3_step_reg.motor_speed;
    assign rsp_item.trip_flag     = s3_step_reg.trip_flag;
    assign rsp_item.trip_total    = s3_step_reg.trip_total;

endmodule

// ----- hdl/dcmpt_checker.sv -----
`timescale 1ns / 1ps

module dcmpt_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rsp_valid,
    input  logic                  rsp_ready,
    input  dcmpt_pkg::out_item_t  rsp_item
);
    import dcmpt_pkg::*;

    // A stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
        else $error("result changed while stalled");

    // Compare values only on update ticks
    a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_item.compare_valid |->
            rsp_item.compare_a == '0 && rsp_item.compare_b == '0)
        else $error("compare values without update tick");

    // Invalid motor id reports nothing
    a_bad_id: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_item.id_ok |->
            rsp_item.motor_speed == '0 && !rsp_item.trip_flag && rsp_item.trip_total == '0)
        else $error("state reported for invalid motor id");

    // Stored speed stays within clamp limits
    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_item.motor_speed <= SPEED_MAX && rsp_item.motor_speed >= SPEED_MIN)
        else $error("motor speed outside clamp range");

endmodule

bind dc_motor_pwm_overcurrent_trip_core dcmpt_checker u_dcmpt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_item  (rsp_item)
);
